// ===== sv/timed_task_table_defines.svh =====
// Assertion macros for the timed task table.
// No dependencies; included by files that assert.
`ifndef TIMED_TASK_TABLE_DEFINES_SVH
`define TIMED_TASK_TABLE_DEFINES_SVH
`ifndef SYNTH
`define TTT_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define TTT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("assertion failed");
`else
`define TTT_ASSERT_IMPL(label, clk, rst_n, prop)
`define TTT_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/ttt_pkg.sv =====
// Shared types and codes for the timed task table.
// No dependencies.
package ttt_pkg;
    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SPEED = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_TICK = 2'd3;

    localparam logic [2:0] ST_ADDED = 3'd0;
    localparam logic [2:0] ST_FIRED = 3'd1;
    localparam logic [2:0] ST_MOVED = 3'd2;
    localparam logic [2:0] ST_UNKNOWN = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;
    localparam logic [2:0] ST_NONE = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [62:0] task_id;
        logic [31:0] owner_id;
        logic [31:0] due_time;
        logic [30:0] advance_secs;
        logic [31:0] now_time;
    } t_req;
endpackage

// ===== sv/ttt_front.sv =====
// Front end: accepts requests into a two-entry queue.
// Depends on ttt_pkg.
module ttt_front import ttt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_req o_req
);
    t_req       r_q [2];
    logic [1:0] r_cnt;
    logic       r_head;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req = r_q[r_head];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_head <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) begin
                r_head <= ~r_head;
            end
        end
        if (w_push) begin
            r_q[r_head ^ r_cnt[0]] <= i_req;
        end
    end
endmodule

// ===== sv/ttt_back.sv =====
// Back end: executes requests by serial scans over the slot table.
// Depends on ttt_pkg.
module ttt_back import ttt_pkg::*; #(
    parameter int TASK_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_req        i_req,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [62:0] o_fired_id,
    output logic [31:0] o_fired_owner,
    output logic [5:0]  o_removed_count,
    output logic        o_last_result
);
    localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_DONE = 3'd2;
    localparam logic [2:0] S_OUT = 3'd3;

    logic [TASK_SLOTS-1:0] r_valid;
    logic [62:0] r_task [TASK_SLOTS];
    logic [31:0] r_owner [TASK_SLOTS];
    logic [31:0] r_due [TASK_SLOTS];
    logic [31:0] r_order [TASK_SLOTS];
    logic [31:0] r_ctr;
    logic [2:0]  r_state;
    t_req        r_req;
    logic [CW-1:0] r_idx;
    logic        r_found;
    logic [IW-1:0] r_best;
    logic [31:0] r_bdue, r_bage;
    logic [5:0]  r_cnt, r_fires;
    logic [2:0]  r_st;
    logic [62:0] r_id;
    logic [31:0] r_own;
    logic [5:0]  r_rc;
    logic        r_last;

    logic [IW-1:0] w_i;
    logic [31:0] w_age, w_nd;
    logic        w_due_ok, w_better;

    assign w_i = r_idx[IW-1:0];
    assign w_age = r_ctr - r_order[w_i];
    assign w_due_ok = r_valid[w_i] && (r_due[w_i] <= r_req.now_time);
    assign w_better = !r_found || (r_due[w_i] < r_bdue) ||
                      ((r_due[w_i] == r_bdue) && (w_age > r_bage));
    assign w_nd = (r_due[r_best] > {1'b0, r_req.advance_secs}) ?
                  r_due[r_best] - {1'b0, r_req.advance_secs} : 32'd0;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_status = r_st;
    assign o_fired_id = r_id;
    assign o_fired_owner = r_own;
    assign o_removed_count = r_rc;
    assign o_last_result = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ctr <= 32'd0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_cnt <= 6'd0;
                        r_fires <= 6'd0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == CW'(TASK_SLOTS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        case (r_req.req_type)
                            REQ_ADD, REQ_SPEED: begin
                                if (!r_found && (r_req.req_type == REQ_ADD ?
                                    !r_valid[w_i] :
                                    (r_valid[w_i] && r_task[w_i] == r_req.task_id)))
                                begin
                                    r_found <= 1'b1;
                                    r_best <= w_i;
                                end
                            end
                            REQ_REMOVE: begin
                                if (r_valid[w_i] && r_owner[w_i] == r_req.owner_id) begin
                                    r_valid[w_i] <= 1'b0;
                                    if (r_cnt != 6'd63) begin
                                        r_cnt <= r_cnt + 6'd1;
                                    end
                                end
                            end
                            default: begin
                                // The count of due tasks tells whether this fire is the last.
                                if (w_due_ok && r_cnt != 6'd63) begin
                                    r_cnt <= r_cnt + 6'd1;
                                end
                                if (w_due_ok && w_better) begin
                                    r_found <= 1'b1;
                                    r_best <= w_i;
                                    r_bdue <= r_due[w_i];
                                    r_bage <= w_age;
                                end
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    case (r_req.req_type)
                        REQ_ADD: begin
                            r_state <= S_OUT;
                            r_last <= 1'b1;
                            r_rc <= 6'd0;
                            r_id <= r_req.task_id;
                            r_own <= r_req.owner_id;
                            if (r_found) begin
                                r_st <= ST_ADDED;
                                r_valid[r_best] <= 1'b1;
                                r_task[r_best] <= r_req.task_id;
                                r_owner[r_best] <= r_req.owner_id;
                                r_due[r_best] <= r_req.due_time;
                                r_order[r_best] <= r_ctr;
                                r_ctr <= r_ctr + 32'd1;
                            end else begin
                                r_st <= ST_FULL;
                            end
                        end
                        REQ_SPEED: begin
                            r_state <= S_OUT;
                            r_last <= 1'b1;
                            r_rc <= 6'd0;
                            r_id <= r_req.task_id;
                            if (!r_found) begin
                                r_st <= ST_UNKNOWN;
                                r_own <= 32'd0;
                            end else if (r_req.now_time >= w_nd) begin
                                r_st <= ST_FIRED;
                                r_own <= r_owner[r_best];
                                r_valid[r_best] <= 1'b0;
                            end else begin
                                r_st <= ST_MOVED;
                                r_own <= 32'd0;
                                r_due[r_best] <= w_nd;
                                r_order[r_best] <= r_ctr;
                                r_ctr <= r_ctr + 32'd1;
                            end
                        end
                        REQ_REMOVE: begin
                            r_state <= S_OUT;
                            r_last <= 1'b1;
                            r_st <= ST_MOVED;
                            r_id <= 63'd0;
                            r_own <= r_req.owner_id;
                            r_rc <= r_cnt;
                        end
                        default: begin
                            r_rc <= 6'd0;
                            if (r_found) begin
                                r_state <= S_OUT;
                                r_st <= ST_FIRED;
                                r_id <= r_task[r_best];
                                r_own <= r_owner[r_best];
                                r_valid[r_best] <= 1'b0;
                                r_fires <= r_fires + 6'd1;
                                r_last <= (r_fires == 6'd31) || (r_cnt == 6'd1);
                            end else if (r_fires == 6'd0) begin
                                r_state <= S_OUT;
                                r_st <= ST_NONE;
                                r_id <= 63'd0;
                                r_own <= 32'd0;
                                r_last <= 1'b1;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (i_ready) begin
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                            r_idx <= '0;
                            r_found <= 1'b0;
                            r_cnt <= 6'd0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/timed_task_table.sv =====
// Each accepted request is queued, scanned over all slots, resolved and then presented as a result.
// The back end takes no new request while one is still in progress; each further tick result
// needs a fresh scan that starts after the previous result is taken.
// The back end scans slots one per cycle through a single compare unit.
// Reset (synchronous, active low) clears slot valid bits, order counter and queue.
`include "timed_task_table_defines.svh"
module timed_task_table import ttt_pkg::*; #(
    parameter int TASK_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [62:0] i_task_id,
    input  logic [31:0] i_owner_id,
    input  logic [31:0] i_due_time,
    input  logic [30:0] i_advance_secs,
    input  logic [31:0] i_now_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [62:0] o_fired_id,
    output logic [31:0] o_fired_owner,
    output logic [5:0]  o_removed_count,
    output logic        o_last_result
);
    // Requests are packed and queued; the back end drains the queue one at a time.
    t_req w_in, w_q;
    logic w_qv, w_qr;

    assign w_in = '{i_req_type, i_task_id, i_owner_id, i_due_time,
                    i_advance_secs, i_now_time};

    ttt_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_req(w_q)
    );

    ttt_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_req(w_q),
        .o_valid, .i_ready, .o_status, .o_fired_id, .o_fired_owner,
        .o_removed_count, .o_last_result
    );

    // A result stays put while stalled, and a final result is followed by idle back end.
    `TTT_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    `TTT_ASSERT_NEXT(a_lastidle, i_clk, i_rst_n, o_valid && i_ready && o_last_result, !o_valid)
    `TTT_ASSERT_IMPL(a_status, i_clk, i_rst_n, o_valid |-> (o_status <= ST_NONE))
endmodule
